// ----- rtl/cpualu_pkg.sv -----
// Package for the processor ALU with flags: operation codes, flag bit positions
// and the request and result payload structs.
// Depends on nothing; the unit, execute and output stage files use it by scoped names.
package cpualu_pkg;

	localparam int MODE_W  = 5;
	localparam int BYTE_W  = 8;
	localparam int WIDE_W  = 16;
	localparam int FLAG_W  = 4;
	localparam int INDEX_W = 3;

	// Operation codes.
	localparam logic [MODE_W-1:0] OP_ADD   = 5'd0;
	localparam logic [MODE_W-1:0] OP_ADC   = 5'd1;
	localparam logic [MODE_W-1:0] OP_SUB   = 5'd2;
	localparam logic [MODE_W-1:0] OP_SBC   = 5'd3;
	localparam logic [MODE_W-1:0] OP_AND   = 5'd4;
	localparam logic [MODE_W-1:0] OP_OR    = 5'd5;
	localparam logic [MODE_W-1:0] OP_XOR   = 5'd6;
	localparam logic [MODE_W-1:0] OP_CP    = 5'd7;
	localparam logic [MODE_W-1:0] OP_INC   = 5'd8;
	localparam logic [MODE_W-1:0] OP_DEC   = 5'd9;
	localparam logic [MODE_W-1:0] OP_CPL   = 5'd10;
	localparam logic [MODE_W-1:0] OP_RLC   = 5'd11;
	localparam logic [MODE_W-1:0] OP_RRC   = 5'd12;
	localparam logic [MODE_W-1:0] OP_RL    = 5'd13;
	localparam logic [MODE_W-1:0] OP_RR    = 5'd14;
	localparam logic [MODE_W-1:0] OP_SLA   = 5'd15;
	localparam logic [MODE_W-1:0] OP_SRA   = 5'd16;
	localparam logic [MODE_W-1:0] OP_SRL   = 5'd17;
	localparam logic [MODE_W-1:0] OP_SWAP  = 5'd18;
	localparam logic [MODE_W-1:0] OP_BIT   = 5'd19;
	localparam logic [MODE_W-1:0] OP_RES   = 5'd20;
	localparam logic [MODE_W-1:0] OP_SET   = 5'd21;
	localparam logic [MODE_W-1:0] OP_ADD16 = 5'd22;

	// Flag bit positions.
	localparam int FLAG_Z = 3;
	localparam int FLAG_N = 2;
	localparam int FLAG_H = 1;
	localparam int FLAG_C = 0;

	typedef struct packed {
		logic [MODE_W-1:0]  mode;
		logic [BYTE_W-1:0]  acc;
		logic [BYTE_W-1:0]  operand;
		logic [FLAG_W-1:0]  flags_in;
		logic [INDEX_W-1:0] bit_index;
		logic [WIDE_W-1:0]  wide_left;
		logic [WIDE_W-1:0]  wide_right;
	} req_t;

	typedef struct packed {
		logic [WIDE_W-1:0] result;
		logic [FLAG_W-1:0] flags_out;
	} rsp_t;

endpackage

// ----- rtl/cpualu_chan_if.sv -----
// Valid/ready channel interface that carries one payload struct per request.
// The payload type is given by the instantiating side, usually from cpualu_pkg.
interface cpualu_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/cpu_alu_with_flags_unit.sv -----
// Processor ALU with flags: input register, combinational execute, result register.
// Path: an accepted request is held in the stage one input register, then in the stage two result register.
// Throughput: one request per cycle, limited only by the result channel taking results.
// Reset: arst_n clears both stage valid bits at once; payload registers are not reset.
// Depends on cpualu_pkg, cpualu_chan_if, cpualu_exec and cpualu_out_stage.
module cpu_alu_with_flags_unit (
	input logic clk,
	input logic arst_n,
	cpualu_chan_if.sink   req,
	cpualu_chan_if.source rsp
);

	// Stage one holds the accepted request; the execute logic works on it and
	// stage two captures the result and flags.
	logic             valid_s1;
	cpualu_pkg::req_t req_s1;
	cpualu_pkg::rsp_t exec_rsp;
	logic             valid_s2;
	cpualu_pkg::rsp_t rsp_s2;
	logic             s2_ready;
	logic             advance;

	// Stage two can load when it is empty or its result leaves this cycle.
	// Stage one can load when it is empty or its request moves to stage two.
	// The ready chain is combinational so a request can enter every cycle while results are taken.
	assign s2_ready  = !valid_s2 || rsp.ready;
	assign advance   = valid_s1 && s2_ready;
	assign req.ready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_s1 <= req.payload;
		end
	end

	cpualu_exec u_exec (
		.req (req_s1),
		.rsp (exec_rsp)
	);

	cpualu_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (advance),
		.take     (rsp.ready),
		.rsp_in   (exec_rsp),
		.valid_s2 (valid_s2),
		.rsp_s2   (rsp_s2)
	);

	assign rsp.valid   = valid_s2;
	assign rsp.payload = rsp_s2;

`ifndef NO_ASSERTIONS
	// A request held back by a full result stage stays put in stage one.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s2_ready |=> valid_s1 && $stable(req_s1))
		else $error("stage one request changed while stalled");

	// An accepted request always occupies stage one on the next cycle.
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> valid_s1)
		else $error("accepted request lost from stage one");

	// A request leaving stage one always lands in stage two.
	a_s2_fill: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("request lost between stages");

	// Compare returns the accumulator it was given.
	a_cp_acc: assert property (@(posedge clk) disable iff (!arst_n)
		advance && req_s1.mode == cpualu_pkg::OP_CP |=>
		rsp_s2.result == {8'h00, $past(req_s1.acc)})
		else $error("compare did not return the accumulator");
`endif

endmodule

// ----- rtl/cpualu_exec.sv -----
// Combinational execute logic of the ALU: result and new flags for one request.
// Depends on cpualu_pkg for the payload structs and operation codes.
module cpualu_exec (
	input  cpualu_pkg::req_t req,
	output cpualu_pkg::rsp_t rsp
);

	logic [7:0]  a;
	logic [7:0]  v;
	logic [3:0]  f;
	logic        cin;
	logic        use_c;
	logic [8:0]  sum9;
	logic [4:0]  hsum5;
	logic [8:0]  diff9;
	logic [4:0]  hdiff5;
	logic [16:0] sum17;
	logic [12:0] hsum13;
	logic [7:0]  mask;
	logic [7:0]  r8;
	logic [15:0] r16;
	logic        wide_op;
	logic [3:0]  nf;
	logic        zf;

	assign a     = req.acc;
	assign v     = req.operand;
	assign f     = req.flags_in;
	assign cin   = f[cpualu_pkg::FLAG_C];
	assign use_c = (req.mode == cpualu_pkg::OP_ADC) || (req.mode == cpualu_pkg::OP_SBC);

	assign sum9   = {1'b0, a} + {1'b0, v} + {8'b0, use_c & cin};
	assign hsum5  = {1'b0, a[3:0]} + {1'b0, v[3:0]} + {4'b0, use_c & cin};
	assign diff9  = {1'b0, a} - {1'b0, v} - {8'b0, use_c & cin};
	assign hdiff5 = {1'b0, a[3:0]} - {1'b0, v[3:0]} - {4'b0, use_c & cin};
	assign sum17  = {1'b0, req.wide_left} + {1'b0, req.wide_right};
	assign hsum13 = {1'b0, req.wide_left[11:0]} + {1'b0, req.wide_right[11:0]};
	assign mask   = 8'b1 << req.bit_index;

	// Byte result first, so the zero flag can be taken from it.
	always_comb begin
		r8      = v;
		wide_op = 1'b0;
		case (req.mode)
			cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: r8 = sum9[7:0];
			cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC: r8 = diff9[7:0];
			cpualu_pkg::OP_CP:   r8 = diff9[7:0];
			cpualu_pkg::OP_AND:  r8 = a & v;
			cpualu_pkg::OP_OR:   r8 = a | v;
			cpualu_pkg::OP_XOR:  r8 = a ^ v;
			cpualu_pkg::OP_INC:  r8 = v + 8'd1;
			cpualu_pkg::OP_DEC:  r8 = v - 8'd1;
			cpualu_pkg::OP_CPL:  r8 = ~a;
			cpualu_pkg::OP_RLC:  r8 = {v[6:0], v[7]};
			cpualu_pkg::OP_RRC:  r8 = {v[0], v[7:1]};
			cpualu_pkg::OP_RL:   r8 = {v[6:0], cin};
			cpualu_pkg::OP_RR:   r8 = {cin, v[7:1]};
			cpualu_pkg::OP_SLA:  r8 = {v[6:0], 1'b0};
			cpualu_pkg::OP_SRA:  r8 = {v[7], v[7:1]};
			cpualu_pkg::OP_SRL:  r8 = {1'b0, v[7:1]};
			cpualu_pkg::OP_SWAP: r8 = {v[3:0], v[7:4]};
			cpualu_pkg::OP_BIT:  r8 = v;
			cpualu_pkg::OP_RES:  r8 = v & ~mask;
			cpualu_pkg::OP_SET:  r8 = v | mask;
			cpualu_pkg::OP_ADD16: wide_op = 1'b1;
			default:             r8 = v;
		endcase
	end

	assign zf = (r8 == 8'h00);

	always_comb begin
		nf = f;
		case (req.mode)
			cpualu_pkg::OP_ADD, cpualu_pkg::OP_ADC: nf = {zf, 1'b0, hsum5[4], sum9[8]};
			cpualu_pkg::OP_SUB, cpualu_pkg::OP_SBC, cpualu_pkg::OP_CP:
				nf = {zf, 1'b1, hdiff5[4], diff9[8]};
			cpualu_pkg::OP_AND:  nf = {zf, 1'b0, 1'b1, 1'b0};
			cpualu_pkg::OP_OR, cpualu_pkg::OP_XOR, cpualu_pkg::OP_SWAP:
				nf = {zf, 3'b000};
			cpualu_pkg::OP_INC:  nf = {zf, 1'b0, v[3:0] == 4'hF, cin};
			cpualu_pkg::OP_DEC:  nf = {zf, 1'b1, v[3:0] == 4'h0, cin};
			cpualu_pkg::OP_CPL:  nf = {f[cpualu_pkg::FLAG_Z], 1'b1, 1'b1, cin};
			cpualu_pkg::OP_RLC, cpualu_pkg::OP_RL, cpualu_pkg::OP_SLA:
				nf = {zf, 1'b0, 1'b0, v[7]};
			cpualu_pkg::OP_RRC, cpualu_pkg::OP_RR, cpualu_pkg::OP_SRA, cpualu_pkg::OP_SRL:
				nf = {zf, 1'b0, 1'b0, v[0]};
			cpualu_pkg::OP_BIT:  nf = {~v[req.bit_index], 1'b0, 1'b1, cin};
			cpualu_pkg::OP_RES, cpualu_pkg::OP_SET: nf = f;
			cpualu_pkg::OP_ADD16: nf = {f[cpualu_pkg::FLAG_Z], 1'b0, hsum13[12], sum17[16]};
			default:             nf = f;
		endcase
	end

	// Compare hands back the accumulator unchanged.
	always_comb begin
		if (wide_op) begin
			r16 = sum17[15:0];
		end else if (req.mode == cpualu_pkg::OP_CP) begin
			r16 = {8'h00, a};
		end else begin
			r16 = {8'h00, r8};
		end
	end

	assign rsp.result    = r16;
	assign rsp.flags_out = nf;

endmodule

// ----- rtl/cpualu_with_flags_unit_top_placeholder.sv -----
// Output register stage of the ALU: holds one finished result until it is taken.
// Depends on cpualu_pkg for the result struct.
module cpualu_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  logic             take,
	input  cpualu_pkg::rsp_t rsp_in,
	output logic             valid_s2,
	output cpualu_pkg::rsp_t rsp_s2
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load) begin
			valid_s2 <= 1'b1;
		end else if (take) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_s2 <= rsp_in;
		end
	end

endmodule
